[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules of the row dot-product block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIMV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/pimv_pkg.sv]
// Types and constants of the packed-integer weight row dot-product block.
// Depends on nothing; used by the controller, the datapath and the top level.
package pimv_pkg;

    localparam int unsigned MagW = 50;
    localparam logic [31:0] CanonNan = 32'h7FC0_0000;
    localparam logic [7:0]  ExpMax = 8'hFF;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_ALIGN, OP_ADD, OP_LZ, OP_RND, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {PH_T1, PH_T2, PH_SUM} t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_ALIGN, S_ADD, S_LZ, S_RND, S_EMIT
    } t_state;

    typedef struct packed {
        t_op    op;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic last;
        logic out_busy;
    } t_status;

    // Leading-zero count of the normalization word; an all-zero word gives MagW.
    function automatic logic [5:0] lzc(input logic [MagW-1:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'(MagW);
        hit = 1'b0;
        for (int i = MagW - 1; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 6'(MagW - 1 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[sv/packed_int_weight_matvec_row.sv]
// An item is accepted only in the idle state, so the block takes a new item only once it is through
// with the last one; a row-end item then passes the emit step, which fills the output register.
// The single shared fp32 normalize/round unit is used in turn by the scale multiply, activation
// multiply and accumulate; a bad-scale item skips them, going back to idle or, when it ends a row,
// to the emit step. A row end waits while the previous result is still unread.
// Reset (i_rst_n low, synchronous): accumulator +0, lane 0, error flag clear, INT4 mode.
module packed_int_weight_matvec_row (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: one register, int8_mode, written whenever i_cfg_we is high.
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // weight_word[31:0], scale_bits[47:32], activation[79:48]
    input  logic        s_axis_tlast,   // last_in_row
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // row_sum[31:0]
    output logic [0:0]  m_axis_tuser    // bad_scale[0]
);
    import pimv_pkg::*;

    // The controller steps each transaction through the datapath: first the
    // code times the scale, then that product times the activation, then the
    // add into the accumulator. Each operation ends in the shared normalize
    // and round steps. A row end hands the sum to the output register, which
    // holds it until the downstream side takes the transaction.
    t_cmd    cmd;
    t_status status;
    logic    bad_scale;

    pimv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pimv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_weight_word (s_axis_tdata[31:0]),
        .i_scale_bits  (s_axis_tdata[47:32]),
        .i_activation  (s_axis_tdata[79:48]),
        .i_last_in_row (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_row_sum     (m_axis_tdata),
        .o_bad_scale   (bad_scale)
    );

    assign m_axis_tuser = bad_scale;

endmodule

[sv/pimv_ctrl.sv]
// Controller of the row dot-product block: sequences the datapath steps per item.
// Depends on pimv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pimv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pimv_pkg::t_status i_status,
    output pimv_pkg::t_cmd    o_cmd
);
    import pimv_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_T1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NOP;
        o_cmd.phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MUL_A;
                end
            end
            S_MUL_A: begin
                // An item with a non-finite scale contributes nothing.
                if (i_status.skip) begin
                    n_state = i_status.last ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.op = OP_MUL_A;
                    n_phase  = PH_T1;
                    n_state  = S_LZ;
                end
            end
            S_MUL_B: begin
                o_cmd.op = OP_MUL_B;
                n_state  = S_LZ;
            end
            S_ALIGN: begin
                o_cmd.op = OP_ALIGN;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = S_LZ;
            end
            S_LZ: begin
                o_cmd.op = OP_LZ;
                n_state  = S_RND;
            end
            S_RND: begin
                o_cmd.op = OP_RND;
                unique case (r_phase)
                    PH_T1: begin
                        n_phase = PH_T2;
                        n_state = S_MUL_B;
                    end
                    PH_T2: begin
                        n_phase = PH_SUM;
                        n_state = S_ALIGN;
                    end
                    default: begin
                        n_state = i_status.last ? S_EMIT : S_IDLE;
                    end
                endcase
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PIMV_ASSERT_NEXT(a_skip_short, i_clk, i_rst_n, (r_state == S_MUL_A && i_status.skip), (r_state == S_IDLE || r_state == S_EMIT))
    `PIMV_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, (o_cmd.op == OP_EMIT), (!i_status.out_busy))
    `PIMV_ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, (o_cmd.op == OP_LOAD), (r_state == S_IDLE && i_in_valid))

endmodule

[sv/pimv_dp.sv]
// Datapath of the row dot-product block: lane select, fp32 multiply, add,
// shared normalize/round unit, accumulator and output register. Uses pimv_pkg.
`include "assert_macros.svh"

module pimv_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pimv_pkg::t_cmd    i_cmd,
    output pimv_pkg::t_status o_status,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic [31:0]       i_weight_word,
    input  logic [15:0]       i_scale_bits,
    input  logic [31:0]       i_activation,
    input  logic              i_last_in_row,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_row_sum,
    output logic              o_bad_scale
);
    import pimv_pkg::*;

    logic                    r_int8;
    logic [2:0]              r_lane;
    logic                    r_sticky;
    logic [31:0]             r_acc;
    logic                    r_out_valid;
    logic [31:0]             r_out_sum;
    logic                    r_out_bad;
    logic                    r_skip, r_last;
    logic                    r_csgn;
    logic [7:0]              r_cmag;
    logic [15:0]             r_scale;
    logic [31:0]             r_act;
    logic [31:0]             r_t;
    logic                    r_sgn, r_sgn_b, r_sub;
    logic [26:0]             r_ma, r_mb;
    logic [MagW-1:0]         r_mag;
    logic signed [11:0]      r_x;
    logic [5:0]              r_lz;
    logic                    r_nan, r_inf;

    // Lane extraction and offset removal.
    logic [7:0] ld_raw;
    logic       ld_sgn;
    logic [7:0] ld_mag;
    logic [2:0] ld_lane_next;
    always_comb begin
        if (r_int8) begin
            ld_raw       = 8'(i_weight_word >> {r_lane[1:0], 3'b000});
            ld_sgn       = !ld_raw[7];
            ld_mag       = ld_raw[7] ? {1'b0, ld_raw[6:0]} : 8'(9'd128 - {1'b0, ld_raw});
            ld_lane_next = {1'b0, 2'(r_lane[1:0] + 2'd1)};
        end else begin
            ld_raw       = {4'b0000, 4'(i_weight_word >> {r_lane, 2'b00})};
            ld_sgn       = !ld_raw[3];
            ld_mag       = ld_raw[3] ? {5'b0, ld_raw[2:0]} : 8'(8'd8 - ld_raw);
            ld_lane_next = 3'(r_lane + 3'd1);
        end
    end

    // First product: code times bf16 scale (scale known finite here).
    logic [7:0]      ma_ms;
    logic [7:0]      ma_es;
    always_comb begin
        ma_es = (r_scale[14:7] == 8'h00) ? 8'h01 : r_scale[14:7];
        ma_ms = {(r_scale[14:7] != 8'h00), r_scale[6:0]};
    end

    // Second product: t times activation.
    logic [7:0]  mb_ea, mb_eb;
    logic [23:0] mb_ma, mb_mb;
    logic        mb_an, mb_ai, mb_az, mb_bn, mb_bi, mb_bz;
    always_comb begin
        mb_ea = (r_t[30:23] == 8'h00) ? 8'h01 : r_t[30:23];
        mb_eb = (r_act[30:23] == 8'h00) ? 8'h01 : r_act[30:23];
        mb_ma = {(r_t[30:23] != 8'h00), r_t[22:0]};
        mb_mb = {(r_act[30:23] != 8'h00), r_act[22:0]};
        mb_an = (r_t[30:23] == ExpMax) && (r_t[22:0] != 23'd0);
        mb_ai = (r_t[30:23] == ExpMax) && (r_t[22:0] == 23'd0);
        mb_az = (r_t[30:0] == 31'd0);
        mb_bn = (r_act[30:23] == ExpMax) && (r_act[22:0] != 23'd0);
        mb_bi = (r_act[30:23] == ExpMax) && (r_act[22:0] == 23'd0);
        mb_bz = (r_act[30:0] == 31'd0);
    end

    // Alignment of accumulator and product for the add.
    logic [31:0] al_big, al_small;
    logic [7:0]  al_eb, al_es, al_d;
    logic [26:0] al_v, al_shift, al_mask;
    logic        al_an, al_ai, al_bn, al_bi;
    always_comb begin
        if (r_acc[30:0] >= r_t[30:0]) begin
            al_big   = r_acc;
            al_small = r_t;
        end else begin
            al_big   = r_t;
            al_small = r_acc;
        end
        al_eb    = (al_big[30:23] == 8'h00) ? 8'h01 : al_big[30:23];
        al_es    = (al_small[30:23] == 8'h00) ? 8'h01 : al_small[30:23];
        al_d     = al_eb - al_es;
        al_v     = {(al_small[30:23] != 8'h00), al_small[22:0], 3'b000};
        if (al_d >= 8'd27) begin
            al_shift = {26'd0, |al_v};
            al_mask  = '0;
        end else begin
            al_mask  = (27'd1 << al_d) - 27'd1;
            al_shift = (al_v >> al_d) | {26'd0, |(al_v & al_mask)};
        end
        al_an = (r_acc[30:23] == ExpMax) && (r_acc[22:0] != 23'd0);
        al_ai = (r_acc[30:23] == ExpMax) && (r_acc[22:0] == 23'd0);
        al_bn = (r_t[30:23] == ExpMax) && (r_t[22:0] != 23'd0);
        al_bi = (r_t[30:23] == ExpMax) && (r_t[22:0] == 23'd0);
    end

    // Add or subtract of aligned significands.
    logic [27:0] ad_sum;
    always_comb begin
        ad_sum = r_sub ? ({1'b0, r_ma} - {1'b0, r_mb}) : ({1'b0, r_ma} + {1'b0, r_mb});
    end

    // Normalize and round to nearest even, subnormals and overflow included.
    logic signed [11:0] rn_p, rn_be, rn_sh;
    logic [5:0]         rn_shc;
    logic [63:0]        rn_ext, rn_q, rn_low, rn_below;
    logic               rn_g, rn_s, rn_up;
    logic [24:0]        rn_r;
    logic [11:0]        rn_ef;
    logic [35:0]        rn_tot;
    logic [31:0]        rn_res;
    always_comb begin
        rn_p   = 12'sd49 - $signed({6'b0, r_lz});
        rn_be  = rn_p + r_x + 12'sd127;
        rn_sh  = rn_p - 12'sd23 + ((rn_be < 12'sd1) ? (12'sd1 - rn_be) : 12'sd0);
        rn_ext = {{(64 - MagW){1'b0}}, r_mag};
        rn_shc = '0;
        rn_low = '0;
        rn_q   = '0;
        rn_below = '0;
        rn_g   = 1'b0;
        rn_s   = 1'b0;
        rn_up  = 1'b0;
        if (rn_sh < 12'sd0) begin
            rn_shc = 6'(-rn_sh);
            rn_q   = rn_ext << rn_shc;
            rn_r   = rn_q[24:0];
        end else begin
            rn_shc   = (rn_sh > 12'sd63) ? 6'd63 : rn_sh[5:0];
            rn_q     = rn_ext >> rn_shc;
            rn_low   = (64'd1 << rn_shc) - 64'd1;
            rn_below = rn_ext & rn_low;
            rn_g     = |(rn_below & ~(rn_low >> 1));
            rn_s     = |(rn_below & (rn_low >> 1));
            rn_up    = rn_g & (rn_s | rn_q[0]);
            rn_r     = rn_q[24:0] + {24'd0, rn_up};
        end
        rn_ef  = (rn_be < 12'sd1) ? 12'd0 : 12'(rn_be - 12'sd1);
        rn_tot = ({24'd0, rn_ef} << 23) + {11'd0, rn_r};
        if (r_nan) begin
            rn_res = CanonNan;
        end else if (r_inf || rn_tot[35:23] >= 13'd255) begin
            rn_res = {r_sgn, ExpMax, 23'd0};
        end else if (r_mag == '0) begin
            rn_res = {r_sgn, 31'd0};
        end else begin
            rn_res = {r_sgn, rn_tot[30:0]};
        end
    end

    logic acc_nan;
    assign acc_nan = (r_acc[30:23] == ExpMax) && (r_acc[22:0] != 23'd0);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int8      <= 1'b0;
            r_lane      <= '0;
            r_sticky    <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_skip      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_int8 <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_lane <= ld_lane_next;
                    r_skip <= (i_scale_bits[14:7] == ExpMax);
                    r_last <= i_last_in_row;
                    if (i_scale_bits[14:7] == ExpMax) begin
                        r_sticky <= 1'b1;
                    end
                end
                OP_RND: begin
                    if (i_cmd.phase == PH_SUM) begin
                        r_acc <= rn_res;
                    end
                end
                OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_acc       <= '0;
                    r_lane      <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_csgn  <= ld_sgn;
                r_cmag  <= ld_mag;
                r_scale <= i_scale_bits;
                r_act   <= i_activation;
            end
            OP_MUL_A: begin
                r_mag <= MagW'(r_cmag * ma_ms);
                r_x   <= $signed({4'b0, ma_es}) - 12'sd134;
                r_sgn <= r_csgn ^ r_scale[15];
                r_nan <= 1'b0;
                r_inf <= 1'b0;
            end
            OP_MUL_B: begin
                r_mag <= MagW'(mb_ma * mb_mb);
                r_x   <= $signed({4'b0, mb_ea}) + $signed({4'b0, mb_eb}) - 12'sd300;
                r_sgn <= r_t[31] ^ r_act[31];
                r_nan <= mb_an || mb_bn || (mb_ai && mb_bz) || (mb_bi && mb_az);
                r_inf <= mb_ai || mb_bi;
            end
            OP_ALIGN: begin
                r_ma    <= {(al_big[30:23] != 8'h00), al_big[22:0], 3'b000};
                r_mb    <= al_shift;
                r_sub   <= al_big[31] ^ al_small[31];
                r_sgn   <= al_ai ? r_acc[31] : (al_bi ? r_t[31] : al_big[31]);
                r_sgn_b <= al_small[31];
                r_x     <= $signed({4'b0, al_eb}) - 12'sd153;
                r_nan   <= al_an || al_bn || (al_ai && al_bi && (r_acc[31] != r_t[31]));
                r_inf   <= al_ai || al_bi;
            end
            OP_ADD: begin
                r_mag <= MagW'(ad_sum);
                if (ad_sum == 28'd0 && !r_inf) begin
                    r_sgn <= r_sgn & r_sgn_b;
                end
            end
            OP_LZ: begin
                r_lz <= lzc(r_mag);
            end
            OP_RND: begin
                if (i_cmd.phase != PH_SUM) begin
                    r_t <= rn_res;
                end
            end
            OP_EMIT: begin
                r_out_sum <= acc_nan ? CanonNan : r_acc;
                r_out_bad <= r_sticky;
            end
            default: begin
            end
        endcase
    end

    assign o_status.skip     = r_skip;
    assign o_status.last     = r_last;
    assign o_status.out_busy = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_row_sum         = r_out_sum;
    assign o_bad_scale       = r_out_bad;

    `PIMV_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, (i_cmd.op == OP_EMIT), (r_acc == 32'd0 && r_lane == 3'd0 && r_out_valid))
    `PIMV_ASSERT_NEXT(a_bad_sticks, i_clk, i_rst_n, (i_cmd.op == OP_LOAD && i_scale_bits[14:7] == ExpMax), (r_sticky && r_skip))
    `PIMV_ASSERT_NEXT(a_sticky_holds, i_clk, i_rst_n, (r_sticky), (r_sticky))

endmodule
